[hdl/bgp_pkg.sv]
// Package for the backtracking grammar parser: symbol codes, grammar tables.
// No dependencies.
`default_nettype none
package bgp_pkg;

  // Symbol codes: 0..6 terminals, 7..10 nonterminals A B T M
  localparam logic [3:0] SymA      = 4'd7;
  localparam logic [3:0] NumTerms  = 4'd7;
  localparam logic [3:0] HistRule  = 4'd8;
  localparam int unsigned MaxResults = 64;

  // Terminal character for a symbol code
  function automatic logic [7:0] term_char(input logic [3:0] s);
    logic [7:0] c;
    case (s)
      4'd0: c = 8'h21;
      4'd1: c = 8'h2B;
      4'd2: c = 8'h2A;
      4'd3: c = 8'h28;
      4'd4: c = 8'h29;
      4'd5: c = 8'h61;
      4'd6: c = 8'h62;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] rule_lhs(input logic [2:0] r);
    logic [3:0] v;
    case (r)
      3'd0: v = 4'd7;
      3'd1, 3'd2: v = 4'd8;
      3'd3, 3'd4: v = 4'd9;
      default: v = 4'd10;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] rule_len(input logic [2:0] r);
    logic [1:0] v;
    case (r)
      3'd1, 3'd3, 3'd5, 3'd6: v = 2'd1;
      default: v = 2'd3;
    endcase
    return v;
  endfunction

  // Right side symbol k (0 = leftmost)
  function automatic logic [3:0] rule_rhs(input logic [2:0] r, input logic [1:0] k);
    logic [3:0] v;
    v = 4'd0;
    case (r)
      3'd0: v = (k == 2'd1) ? 4'd8 : 4'd0;
      3'd1: v = 4'd9;
      3'd2: v = (k == 2'd0) ? 4'd9 : ((k == 2'd1) ? 4'd1 : 4'd8);
      3'd3: v = 4'd10;
      3'd4: v = (k == 2'd0) ? 4'd10 : ((k == 2'd1) ? 4'd2 : 4'd9);
      3'd5: v = 4'd5;
      3'd6: v = 4'd6;
      default: v = (k == 2'd0) ? 4'd3 : ((k == 2'd1) ? 4'd8 : 4'd4);
    endcase
    return v;
  endfunction

  // First rule for a nonterminal
  function automatic logic [2:0] first_rule(input logic [3:0] nt);
    logic [2:0] v;
    case (nt)
      4'd7: v = 3'd0;
      4'd8: v = 3'd1;
      4'd9: v = 3'd3;
      default: v = 3'd5;
    endcase
    return v;
  endfunction

  // Whether rule r+1 shares the left side of rule r
  function automatic logic has_next(input logic [2:0] r);
    return (r == 3'd1) || (r == 3'd3) || (r == 3'd5) || (r == 3'd6);
  endfunction

endpackage
`default_nettype wire

[hdl/backtracking_grammar_parser_unit.sv]
// Top level of the backtracking grammar parser; sequencer over two stack memories.
// Depends on bgp_pkg.
`default_nettype none
// Characters are taken one per cycle and stored. An item with last_i set
// starts the parse. A sequencer does one goal or history stack operation per
// cycle, with one memory access per stack per cycle. A match goes through
// S_NORM and S_NEXEC, a backtrack step through S_BACK and S_BEXEC. A rule
// expansion goes through S_NORM, S_NEXEC and S_PUSH, which pushes the
// right-side symbols. The number of steps grows exponentially with nesting
// depth in the worst case. On accept the history stack is walked twice: once
// to count the rules (S_CNT, S_CRD) and once to stream them (S_EMIT, S_ERD).
// The input is not ready during a run. A stack push beyond STACK_DEPTH
// entries, a string longer than MAX_LEN or more than 64 rules gives a single
// reject item with overflow_o set.
module backtracking_grammar_parser_unit #(
  parameter int unsigned MAX_LEN     = 32,
  parameter int unsigned STACK_DEPTH = 128
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [7:0] symbol_i,
  input  wire logic       last_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output logic            accepted_o,
  output logic            overflow_o,
  output logic [3:0]      rule_number_o,
  output logic            final_res_o
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned BW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  // Sequencer states
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_NORM  = 4'd1;  // issue reads for normal step
  localparam logic [3:0] S_NEXEC = 4'd2;
  localparam logic [3:0] S_PUSH  = 4'd3;  // push rule rhs, one a cycle
  localparam logic [3:0] S_BACK  = 4'd4;
  localparam logic [3:0] S_BEXEC = 4'd5;
  localparam logic [3:0] S_CNT   = 4'd6;  // count rules
  localparam logic [3:0] S_CRD   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_ERD   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_REJ   = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [LW-1:0] len_q, len_d, pos_q, pos_d;
  logic          long_q, long_d;
  logic [PW-1:0] gp_q, gp_d, hp_q, hp_d, k_q, k_d;
  logic [2:0]    rule_q, rule_d;
  logic [1:0]    pk_q, pk_d;
  logic          pmode_q, pmode_d;    // after push: 0 normal, 1 stay in backtrack
  logic [6:0]    cnt_q, cnt_d, idx_q, idx_d;
  logic          ovf_q, ovf_d, acc_q, acc_d;
  logic          last_q, last_d;
  logic [3:0]    rnum_q, rnum_d;

  logic [7:0] buf_mem [MAX_LEN];
  logic [3:0] goal_mem [STACK_DEPTH];
  logic [3:0] hist_mem [STACK_DEPTH];
  logic [7:0] buf_rd_q;
  logic [3:0] goal_rd_q, hist_rd_q;

  // Memory controls
  logic          buf_we, goal_we, hist_we;
  logic [BW-1:0] buf_wa, buf_ra;
  logic [AW-1:0] goal_a, hist_a, hist_ra;
  logic [3:0]    goal_wd, hist_wd;

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[buf_wa] <= symbol_i;
    end
    buf_rd_q <= buf_mem[buf_ra];
    if (goal_we) begin
      goal_mem[goal_a] <= goal_wd;
    end
    goal_rd_q <= goal_mem[goal_a];
    if (hist_we) begin
      hist_mem[hist_a] <= hist_wd;
    end
    hist_rd_q <= hist_mem[hist_ra];
  end

  logic [3:0] e;
  logic [2:0] er, nr;
  logic [1:0] en;

  always_comb begin
    state_d = state_q; len_d = len_q; pos_d = pos_q; long_d = long_q;
    gp_d = gp_q; hp_d = hp_q; k_d = k_q; rule_d = rule_q; pk_d = pk_q;
    pmode_d = pmode_q; cnt_d = cnt_q; idx_d = idx_q; ovf_d = ovf_q;
    acc_d = acc_q; last_d = last_q; rnum_d = rnum_q;
    buf_we = 1'b0; goal_we = 1'b0; hist_we = 1'b0;
    buf_wa = len_q[BW-1:0]; buf_ra = pos_q[BW-1:0];
    goal_a = gp_q[AW-1:0] - AW'(1); hist_a = hp_q[AW-1:0]; hist_ra = hp_q[AW-1:0] - AW'(1);
    goal_wd = 4'd0; hist_wd = 4'd0;
    e = hist_rd_q; er = e[2:0]; nr = er + 3'd1; en = bgp_pkg::rule_len(er);
    ready_o = (state_q == S_LOAD);
    valid_o = (state_q == S_OUT);
    case (state_q)
      S_LOAD: begin
        if (valid_i) begin
          if (len_q < LW'(MAX_LEN)) begin
            buf_we = 1'b1; len_d = len_q + LW'(1);
          end else begin
            long_d = 1'b1;
          end
          if (last_i) begin
            if (long_q || len_q >= LW'(MAX_LEN)) begin
              state_d = S_REJ; ovf_d = 1'b1;
            end else begin
              goal_we = 1'b1; goal_a = '0; goal_wd = bgp_pkg::SymA;
              gp_d = PW'(1); hp_d = '0; pos_d = '0; state_d = S_NORM;
            end
          end
        end
      end
      S_NORM: begin
        if (gp_q == '0 && pos_q == len_q) begin
          state_d = S_CNT; cnt_d = '0; k_d = '0; ovf_d = 1'b0;
        end else if (gp_q == '0 || pos_q >= len_q) begin
          state_d = S_BACK;
        end else begin
          state_d = S_NEXEC;  // goal top and buffer read this cycle
        end
      end
      S_NEXEC: begin
        if (goal_rd_q < bgp_pkg::NumTerms) begin
          if (bgp_pkg::term_char(goal_rd_q) == buf_rd_q) begin
            if (hp_q >= PW'(STACK_DEPTH)) begin
              state_d = S_REJ; ovf_d = 1'b1;
            end else begin
              gp_d = gp_q - PW'(1); hist_we = 1'b1; hist_wd = goal_rd_q;
              hp_d = hp_q + PW'(1); pos_d = pos_q + LW'(1); state_d = S_NORM;
            end
          end else begin
            state_d = S_BACK;
          end
        end else begin
          gp_d = gp_q - PW'(1);
          rule_d = bgp_pkg::first_rule(goal_rd_q);
          if (hp_q >= PW'(STACK_DEPTH)) begin
            state_d = S_REJ; ovf_d = 1'b1;
          end else begin
            hist_we = 1'b1; hist_wd = {1'b1, bgp_pkg::first_rule(goal_rd_q)};
            hp_d = hp_q + PW'(1);
            pk_d = bgp_pkg::rule_len(bgp_pkg::first_rule(goal_rd_q));
            pmode_d = 1'b0; state_d = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (pk_q == 2'd0) begin
          state_d = pmode_q ? S_BACK : S_NORM;
        end else if (gp_q >= PW'(STACK_DEPTH)) begin
          state_d = S_REJ; ovf_d = 1'b1;
        end else begin
          goal_we = 1'b1; goal_a = gp_q[AW-1:0];
          goal_wd = bgp_pkg::rule_rhs(rule_q, pk_q - 2'd1);
          gp_d = gp_q + PW'(1); pk_d = pk_q - 2'd1;
        end
      end
      S_BACK: begin
        if (hp_q == '0) begin
          state_d = S_REJ; ovf_d = 1'b0;
        end else begin
          hp_d = hp_q - PW'(1); state_d = S_BEXEC;  // read top
        end
      end
      S_BEXEC: begin
        if (e < bgp_pkg::HistRule) begin
          if (pos_q > '0) pos_d = pos_q - LW'(1);
          if (gp_q >= PW'(STACK_DEPTH)) begin
            state_d = S_REJ; ovf_d = 1'b1;
          end else begin
            goal_we = 1'b1; goal_a = gp_q[AW-1:0]; goal_wd = e;
            gp_d = gp_q + PW'(1); state_d = S_BACK;
          end
        end else begin
          k_d = (gp_q >= PW'(en)) ? gp_q - PW'(en) : '0;
          gp_d = k_d;
          if (bgp_pkg::has_next(er)) begin
            if (hp_q >= PW'(STACK_DEPTH)) begin
              state_d = S_REJ; ovf_d = 1'b1;
            end else begin
              hist_we = 1'b1; hist_wd = {1'b1, nr}; hp_d = hp_q + PW'(1);
              rule_d = nr; pk_d = bgp_pkg::rule_len(nr); pmode_d = 1'b0;
              state_d = S_PUSH;
            end
          end else if (k_d >= PW'(STACK_DEPTH)) begin
            state_d = S_REJ; ovf_d = 1'b1;
          end else begin
            goal_we = 1'b1; goal_a = k_d[AW-1:0]; goal_wd = bgp_pkg::rule_lhs(er);
            gp_d = k_d + PW'(1); state_d = S_BACK;
          end
        end
      end
      // Count rule entries; hist read at k
      S_CNT: begin
        if (k_q == hp_q) begin
          if (cnt_q > 7'(bgp_pkg::MaxResults)) begin
            state_d = S_REJ; ovf_d = 1'b1;
          end else begin
            k_d = '0; idx_d = '0; state_d = S_EMIT;
          end
        end else begin
          hist_ra = k_q[AW-1:0]; state_d = S_CRD;
        end
      end
      S_CRD: begin
        if (e >= bgp_pkg::HistRule) cnt_d = cnt_q + 7'd1;
        k_d = k_q + PW'(1); state_d = S_CNT;
      end
      S_EMIT: begin
        hist_ra = k_q[AW-1:0]; state_d = S_ERD;
      end
      S_ERD: begin
        k_d = k_q + PW'(1);
        if (e >= bgp_pkg::HistRule) begin
          acc_d = 1'b1; ovf_d = 1'b0; rnum_d = {1'b0, er} + 4'd1;
          last_d = (idx_q == cnt_q - 7'd1); idx_d = idx_q + 7'd1;
          state_d = S_OUT;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_REJ: begin
        acc_d = 1'b0; rnum_d = 4'd0; last_d = 1'b1; state_d = S_OUT;
      end
      S_OUT: begin
        if (ready_i) begin
          if (last_q) begin
            state_d = S_LOAD; len_d = '0; long_d = 1'b0; ovf_d = 1'b0;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; len_q <= '0; pos_q <= '0; long_q <= 1'b0;
      gp_q <= '0; hp_q <= '0; k_q <= '0; rule_q <= '0; pk_q <= '0;
      pmode_q <= 1'b0; cnt_q <= '0; idx_q <= '0; ovf_q <= 1'b0;
      acc_q <= 1'b0; last_q <= 1'b0; rnum_q <= '0;
    end else begin
      state_q <= state_d; len_q <= len_d; pos_q <= pos_d; long_q <= long_d;
      gp_q <= gp_d; hp_q <= hp_d; k_q <= k_d; rule_q <= rule_d; pk_q <= pk_d;
      pmode_q <= pmode_d; cnt_q <= cnt_d; idx_q <= idx_d; ovf_q <= ovf_d;
      acc_q <= acc_d; last_q <= last_d; rnum_q <= rnum_d;
    end
  end

  assign accepted_o    = acc_q;
  assign overflow_o    = ovf_q;
  assign rule_number_o = rnum_q;
  assign final_res_o   = last_q;

endmodule
`default_nettype wire

[hdl/bgp_checker.sv]
// Port-level checks for the backtracking grammar parser, bound to the top level.
// Depends on backtracking_grammar_parser_unit ports only.
`default_nettype none
module bgp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       ready_o,
  input wire logic       valid_o,
  input wire logic       ready_i,
  input wire logic       accepted_o,
  input wire logic       overflow_o,
  input wire logic [3:0] rule_number_o,
  input wire logic       final_res_o
);
  // Held result does not change while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(rule_number_o) && $stable(final_res_o))
    else $error("result changed while stalled");
  // Never take input while a result is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(valid_o && ready_o))
    else $error("input ready during output");
  // Accept carries a rule, a reject carries none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (accepted_o == (rule_number_o != 4'd0)))
    else $error("rule number and accepted flag disagree");
  // Overflow only on a final reject
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && overflow_o |-> !accepted_o && final_res_o)
    else $error("overflow on a non-final or accepted item");
endmodule

bind backtracking_grammar_parser_unit bgp_checker u_bgp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .ready_o(ready_o),
  .valid_o(valid_o), .ready_i(ready_i), .accepted_o(accepted_o),
  .overflow_o(overflow_o), .rule_number_o(rule_number_o), .final_res_o(final_res_o)
);
`default_nettype wire

[verif/backtracking_grammar_parser_unit_tb.sv]
// Testbench for backtracking_grammar_parser_unit: strings go in, rule numbers
// come out and are checked against a parser model kept here. Depends on bgp_pkg.
`timescale 1ns / 1ps
module backtracking_grammar_parser_unit_tb;

  localparam int unsigned LineMax   = 32;
  localparam int unsigned StackMax  = 128;
  localparam int unsigned WdogLimit = 200000;
  localparam int unsigned TailWait  = 400;

  // parser walk direction
  localparam bit ModeForward = 1'b0;
  localparam bit ModeRetreat = 1'b1;

  // terminal and nonterminal codes
  localparam logic [3:0] TBang = 4'd0, TPlus = 4'd1, TStar = 4'd2, TOpen = 4'd3;
  localparam logic [3:0] TClose = 4'd4, TLitA = 4'd5, TLitB = 4'd6;
  localparam logic [3:0] NtB = 4'd8, NtT = 4'd9, NtM = 4'd10;

  // grammar as seen by the checker
  localparam logic [7:0] CharOf [7] = '{8'h21, 8'h2B, 8'h2A, 8'h28, 8'h29, 8'h61, 8'h62};
  localparam logic [3:0] LeftOf [8] = '{bgp_pkg::SymA, NtB, NtB, NtT, NtT, NtM, NtM, NtM};
  localparam int unsigned SizeOf [8] = '{3, 1, 3, 1, 3, 1, 1, 3};
  localparam logic [3:0] RightOf [8][3] = '{
    '{TBang, NtB, TBang}, '{NtT, 4'd0, 4'd0}, '{NtT, TPlus, NtB}, '{NtM, 4'd0, 4'd0},
    '{NtM, TStar, NtT}, '{TLitA, 4'd0, 4'd0}, '{TLitB, 4'd0, 4'd0},
    '{TOpen, NtB, TClose}};

  typedef struct packed {
    logic       acc;
    logic       ovf;
    logic [3:0] rule;
    logic       fin;
  } verdict_t;

  typedef struct {
    logic [7:0] sym;
    bit         last;
    bit         chk;
    bit         acc;
    bit         ovf;
  } char_item_t;

  typedef logic [7:0] line_q_t[$];

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       valid_i = 1'b0;
  logic       ready_o;
  logic [7:0] symbol_i = 8'h00;
  logic       last_i = 1'b0;
  logic       valid_o;
  logic       ready_i = 1'b0;
  logic       accepted_o;
  logic       overflow_o;
  logic [3:0] rule_number_o;
  logic       final_res_o;

  verdict_t   rules_due[$];
  char_item_t plan[$];
  logic [7:0] line_seen[$];
  int unsigned n_err = 0;
  int unsigned n_out = 0;
  int unsigned quiet = 0;
  bit          idle_on = 1'b1;
  bit          sending = 1'b1;

  backtracking_grammar_parser_unit u_dut (
    .clk_i, .rst_ni, .valid_i, .ready_o, .symbol_i, .last_i,
    .valid_o, .ready_i, .accepted_o, .overflow_o, .rule_number_o, .final_res_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Top-down parse with backtracking; fills res with the expected items
  function automatic void parse_line(input line_q_t line, input bit overlong,
                                     ref verdict_t res[$]);
    logic [3:0]  goal [StackMax];
    logic [3:0]  hist [StackMax];
    int unsigned gp, hp, pos, len, r, n, cnt, i;
    logic [3:0]  top, e, nt;
    bit          mode;
    int          outcome;
    verdict_t    v;
    res = {};
    len = line.size();
    gp = 1; hp = 0; pos = 0; mode = ModeForward;
    goal[0] = bgp_pkg::SymA;
    outcome = overlong ? -1 : 2;
    while (outcome == 2) begin
      if (mode == ModeForward) begin
        if (gp == 0 && pos == len) begin
          outcome = 1;
        end else if (gp == 0 || pos >= len) begin
          mode = ModeRetreat;
        end else begin
          top = goal[gp-1];
          if (top < bgp_pkg::NumTerms) begin
            if (CharOf[top] == line[pos]) begin
              gp--;
              if (hp >= StackMax) outcome = -1;
              else begin
                hist[hp] = top;
                hp++;
                pos++;
              end
            end else begin
              mode = ModeRetreat;
            end
          end else begin
            gp--;
            for (r = 0; r < 8; r++) if (LeftOf[r] == top) break;
            // expand: history entry, then right side reversed
            if (hp >= StackMax) outcome = -1;
            else begin
              hist[hp] = bgp_pkg::HistRule + 4'(r);
              hp++;
              for (n = SizeOf[r]; n > 0 && outcome == 2; n--)
                if (gp >= StackMax) outcome = -1;
                else begin
                  goal[gp] = RightOf[r][n-1];
                  gp++;
                end
            end
          end
        end
      end else begin
        if (hp == 0) begin
          outcome = 0;
        end else begin
          hp--;
          e = hist[hp];
          if (e < bgp_pkg::HistRule) begin
            if (pos > 0) pos--;
            if (gp >= StackMax) outcome = -1;
            else begin
              goal[gp] = e;
              gp++;
            end
          end else begin
            r = int'(e - bgp_pkg::HistRule) & 7;
            nt = LeftOf[r];
            gp = (gp >= SizeOf[r]) ? gp - SizeOf[r] : 0;
            for (r = r + 1; r < 8; r++) if (LeftOf[r] == nt) break;
            if (r < 8) begin
              if (hp >= StackMax) outcome = -1;
              else begin
                hist[hp] = bgp_pkg::HistRule + 4'(r);
                hp++;
                for (n = SizeOf[r]; n > 0 && outcome == 2; n--)
                  if (gp >= StackMax) outcome = -1;
                  else begin
                    goal[gp] = RightOf[r][n-1];
                    gp++;
                  end
                mode = ModeForward;
              end
            end else begin
              if (gp >= StackMax) outcome = -1;
              else begin
                goal[gp] = nt;
                gp++;
              end
            end
          end
        end
      end
    end
    cnt = 0;
    if (outcome == 1) begin
      for (i = 0; i < hp; i++) if (hist[i] >= bgp_pkg::HistRule) cnt++;
      if (cnt > bgp_pkg::MaxResults) outcome = -1;
    end
    if (outcome == 1) begin
      n = 0;
      for (i = 0; i < hp; i++) begin
        if (hist[i] < bgp_pkg::HistRule) continue;
        n++;
        v.acc = 1'b1; v.ovf = 1'b0;
        v.rule = hist[i] - bgp_pkg::HistRule + 4'd1;
        v.fin = (n == cnt);
        res = {res, v};
      end
    end else begin
      v.acc = 1'b0; v.ovf = (outcome < 0); v.rule = 4'd0; v.fin = 1'b1;
      res = {res, v};
    end
  endfunction

  // Random well-formed pieces of the grammar
  task automatic gen_m(ref line_q_t s, input int d);
    case ($urandom_range(0, (d > 0) ? 4 : 1))
      0: s = {s, CharOf[TLitA]};
      1: s = {s, CharOf[TLitB]};
      2, 3: s = {s, CharOf[TLitA]};
      default: begin
        s = {s, CharOf[TOpen]};
        gen_b(s, d - 1);
        s = {s, CharOf[TClose]};
      end
    endcase
  endtask

  task automatic gen_t(ref line_q_t s, input int d);
    gen_m(s, d);
    if ($urandom_range(0, 2) == 0) begin
      s = {s, CharOf[TStar]};
      gen_t(s, d);
    end
  endtask

  task automatic gen_b(ref line_q_t s, input int d);
    gen_t(s, d);
    if ($urandom_range(0, 2) == 0) begin
      s = {s, CharOf[TPlus]};
      gen_b(s, d);
    end
  endtask

  // Append one string to the plan; typed verdict only where it is obvious
  task automatic add_line(input line_q_t s, input bit chk, input bit acc, input bit ovf);
    char_item_t it;
    foreach (s[k]) begin
      it.sym = s[k]; it.last = (k == s.size() - 1);
      it.chk = chk; it.acc = acc; it.ovf = ovf;
      plan = {plan, it};
    end
  endtask

  task automatic add_text(input string t, input bit chk, input bit acc, input bit ovf);
    line_q_t s;
    for (int k = 0; k < t.len(); k++) s = {s, t[k]};
    add_line(s, chk, acc, ovf);
  endtask

  // Offer one item after a random gap; valid stays high across back-to-back items
  task automatic send_item(input char_item_t it);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i  <= 1'b1;
    symbol_i <= it.sym;
    last_i   <= it.last;
    do @(posedge clk_i); while (!ready_o);
  endtask

  // Stimulus
  initial begin
    line_q_t    s;
    verdict_t   chk_res[$];
    line_q_t    cur;
    int unsigned pick;
    add_text("!a!", 1, 1, 0);
    add_text("!b!", 0, 0, 0);
    add_text("!(a)!", 0, 0, 0);
    add_text("!a+b*a!", 0, 0, 0);
    add_text("!!", 1, 0, 0);
    add_text("!", 1, 0, 0);
    s = {8'hFF}; add_line(s, 1, 0, 0);
    s = {8'h00}; add_line(s, 1, 0, 0);
    add_text("!a*b!x", 1, 0, 0);
    // random part: mostly well-formed, some broken, some noise, a few too long
    while (plan.size() < 300) begin
      s = {};
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        s = {s, CharOf[TBang]};
        gen_b(s, $urandom_range(0, 2));
        s = {s, CharOf[TBang]};
        if (pick >= 10) s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
        if (s.size() > LineMax) s = s[0:LineMax-1];
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 6)) s = {s, 8'($urandom)};
      end else begin
        repeat ($urandom_range(LineMax + 1, LineMax + 4)) s = {s, 8'($urandom)};
      end
      add_line(s, pick >= 18, 0, 1);
    end
    // typed verdicts against the checker's own model
    foreach (plan[k]) begin
      cur = {cur, plan[k].sym};
      if (plan[k].last) begin
        parse_line(cur, cur.size() > LineMax, chk_res);
        if (plan[k].chk && (chk_res[0].acc != plan[k].acc || chk_res[0].ovf != plan[k].ovf)) begin
          $display("%0t: verdict mismatch expected acc=%0d ovf=%0d actual acc=%0d ovf=%0d",
                   $time, plan[k].acc, plan[k].ovf, chk_res[0].acc, chk_res[0].ovf);
          n_err++;
        end
        cur = {};
      end
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[k]) begin
      if (k % 60 == 59) idle_on = !idle_on;
      send_item(plan[k]);
    end
    valid_i <= 1'b0;
    sending = 1'b0;
  end

  // Receiver with random stalls and one long hold-off
  initial begin
    int unsigned stall;
    bit          held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (n_out >= 6 && !held) begin
        stall = 1500;
        held = 1'b1;
      end
      if (stall > 0) begin
        ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      ready_i <= 1'b1;
      do @(posedge clk_i); while (!valid_o);
    end
  end

  // Collect accepted characters; predict on the closing one
  always @(posedge clk_i) begin
    verdict_t got;
    verdict_t want;
    verdict_t fresh[$];
    if (rst_ni && valid_i && ready_o) begin
      line_seen = {line_seen, symbol_i};
      if (last_i) begin
        parse_line(line_seen, line_seen.size() > LineMax, fresh);
        rules_due = {rules_due, fresh};
        line_seen = {};
      end
    end
    if (rst_ni && valid_o && ready_i) begin
      n_out++;
      got = '{accepted_o, overflow_o, rule_number_o, final_res_o};
      if (rules_due.size() == 0) begin
        $display("%0t: unexpected item acc=%0d ovf=%0d rule=%0d fin=%0d", $time,
                 got.acc, got.ovf, got.rule, got.fin);
        n_err++;
      end else begin
        want = rules_due.pop_front();
        if (got.acc != want.acc) begin
          $display("%0t: accepted expected %0d actual %0d", $time, want.acc, got.acc);
          n_err++;
        end
        if (got.ovf != want.ovf) begin
          $display("%0t: overflow expected %0d actual %0d", $time, want.ovf, got.ovf);
          n_err++;
        end
        if (got.rule != want.rule) begin
          $display("%0t: rule_number expected %0d actual %0d", $time, want.rule, got.rule);
          n_err++;
        end
        if (got.fin != want.fin) begin
          $display("%0t: final_res expected %0d actual %0d", $time, want.fin, got.fin);
          n_err++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WdogLimit) begin
      $display("backtracking_grammar_parser_unit_tb: done, errors");
      $finish;
    end
  end

  // End of run: let the last prediction land before waiting for it to drain
  initial begin
    wait (!sending);
    repeat (2) @(posedge clk_i);
    wait (rules_due.size() == 0);
    repeat (TailWait) @(posedge clk_i);
    if (n_err == 0 && rules_due.size() == 0) begin
      $display("backtracking_grammar_parser_unit_tb: done, clean");
    end else begin
      $display("backtracking_grammar_parser_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/bgp_pkg.sv
hdl/backtracking_grammar_parser_unit.sv
hdl/bgp_checker.sv
verif/backtracking_grammar_parser_unit_tb.sv
